@@ sv/shm_pkg.sv @@
// Shared constants and types for the sliding histogram rank filter.
`default_nettype none

package shm_pkg;

	// Pixel and bin geometry
	localparam int PIXEL_BITS  = 8;
	localparam int NUM_BINS    = 1 << PIXEL_BITS;
	localparam int BIN_W       = 4;
	localparam int RANK_W      = 4;
	localparam int PORT_PIX_W  = 8;
	// Running count over all bins: NUM_BINS * 15 fits in PIXEL_BITS + BIN_W bits
	localparam int ACC_W       = PIXEL_BITS + BIN_W;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [BIN_W-1:0]      bin_t;
	typedef logic [ACC_W-1:0]      acc_t;
	typedef logic [RANK_W-1:0]     rank_t;
	typedef logic [2:0]            upd_cnt_t;

	// Six bin updates per item: three removals, then three additions
	localparam upd_cnt_t REMOVE_N = 3'd3;
	localparam upd_cnt_t UPD_LAST = 3'd5;

	localparam rank_t RANK_RESET  = 4'd5;
	localparam bin_t  WINDOW_SIZE = 4'd9;
	localparam bin_t  BIN_INC     = 4'd1;
	localparam bin_t  BIN_DEC     = 4'hF;

endpackage

`default_nettype wire

@@ sv/shm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module shm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/sliding_histogram_median_3x3_unit.sv @@
// Top level of the 3x3 sliding histogram rank filter.
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------------
//   in      | in_valid / in_ready        | add_*, remove_*, row_start, emit
//   out     | out_valid / out_ready      | median_value
//   cfg     | cfg_wr_en (no wait)        | cfg_wr_data (rank)
//
// An item is accepted, the histogram is reset if row_start is set, and six read-modify-write
// bin updates, each a RAM read then a write, go through the histogram RAM port.
// With emit set, the rank scan reads one bin per cycle, up to all NUM_BINS bins, and
// then loads the output register once any prior result has been taken.
// Reset clears all bin valid bits at once; an invalid bin reads as zero. in_ready is
// low while an item is in work, including while its result waits for the output register.
`default_nettype none

module sliding_histogram_median_3x3_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [shm_pkg::RANK_W-1:0]      cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [shm_pkg::PORT_PIX_W-1:0]  add_top,
	input  wire logic [shm_pkg::PORT_PIX_W-1:0]  add_mid,
	input  wire logic [shm_pkg::PORT_PIX_W-1:0]  add_bottom,
	input  wire logic [shm_pkg::PORT_PIX_W-1:0]  remove_top,
	input  wire logic [shm_pkg::PORT_PIX_W-1:0]  remove_mid,
	input  wire logic [shm_pkg::PORT_PIX_W-1:0]  remove_bottom,
	input  wire logic                            row_start,
	input  wire logic                            emit,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [shm_pkg::PORT_PIX_W-1:0]  median_value
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_RD    = 6'b000100,
		ST_WR    = 6'b001000,
		ST_SCAN  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                  state_q;
	shm_pkg::rank_t          rank_q;
	shm_pkg::pix_t           upd_pix_q [6];
	logic                    emit_q;
	shm_pkg::upd_cnt_t       upd_cnt_q;
	logic [shm_pkg::NUM_BINS-1:0] valid_q;
	logic                    rvalid_s1;
	shm_pkg::pix_t           scan_addr_q;
	logic                    scan_issue_q;
	logic                    rd_vld_s1;
	shm_pkg::pix_t           rd_addr_s1;
	shm_pkg::acc_t           acc_q;
	shm_pkg::pix_t           res_q;
	logic                    out_valid_q;
	logic [shm_pkg::PORT_PIX_W-1:0] median_q;

	// RAM port signals
	logic                    ram_we;
	shm_pkg::pix_t           ram_waddr;
	shm_pkg::bin_t           ram_wdata;
	shm_pkg::pix_t           ram_raddr;
	shm_pkg::bin_t           ram_rdata;

	// Shared adder
	shm_pkg::bin_t           bin_s1;
	shm_pkg::pix_t           upd_pix;
	logic                    removing;
	shm_pkg::acc_t           op_a;
	shm_pkg::acc_t           op_b;
	shm_pkg::acc_t           sum;
	logic                    rank_hit;
	logic                    scan_done;
	logic                    out_free;

	shm_ram #(
		.WIDTH(shm_pkg::BIN_W),
		.DEPTH(shm_pkg::NUM_BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Select the pixel of the current bin update and the shared adder operands
	always_comb begin
		upd_pix  = upd_pix_q[upd_cnt_q];
		removing = (upd_cnt_q < shm_pkg::REMOVE_N);
		bin_s1   = rvalid_s1 ? ram_rdata : '0;
		if (state_q == ST_SCAN) begin
			op_a = acc_q;
			op_b = shm_pkg::acc_t'(bin_s1);
		end else begin
			op_a = shm_pkg::acc_t'(bin_s1);
			op_b = removing ? shm_pkg::acc_t'(shm_pkg::BIN_DEC)
			                : shm_pkg::acc_t'(shm_pkg::BIN_INC);
		end
		sum       = op_a + op_b;
		rank_hit  = (sum >= shm_pkg::acc_t'(rank_q));
		scan_done = rd_vld_s1 && (rank_hit || (rd_addr_s1 == '1));
		out_free  = !out_valid_q || out_ready;
	end

	// Drive the histogram RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = upd_pix;
		ram_wdata = sum[shm_pkg::BIN_W-1:0];
		ram_raddr = (state_q == ST_SCAN) ? scan_addr_q : upd_pix;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = shm_pkg::WINDOW_SIZE;
			end
			ST_WR: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer, bin valid bits and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rank_q       <= shm_pkg::RANK_RESET;
			upd_cnt_q    <= '0;
			valid_q      <= '0;
			rvalid_s1    <= 1'b0;
			scan_addr_q  <= '0;
			scan_issue_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rank_q <= cfg_wr_data;
			end
			// load the result from the emit step, drop it once taken
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			rvalid_s1 <= valid_q[ram_raddr];
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						upd_cnt_q <= '0;
						state_q   <= row_start ? ST_CLEAR : ST_RD;
					end
				end
				ST_CLEAR: begin
					// one window of all padding: bin 0 holds nine
					valid_q <= {{(shm_pkg::NUM_BINS-1){1'b0}}, 1'b1};
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					valid_q[upd_pix] <= 1'b1;
					if (upd_cnt_q == shm_pkg::UPD_LAST) begin
						scan_addr_q  <= '0;
						scan_issue_q <= 1'b1;
						acc_q        <= '0;
						state_q      <= emit_q ? ST_SCAN : ST_IDLE;
					end else begin
						upd_cnt_q <= upd_cnt_q + 3'd1;
						state_q   <= ST_RD;
					end
				end
				ST_SCAN: begin
					// issue one bin read a cycle, accumulate the returned bin
					rd_vld_s1    <= scan_issue_q && !scan_done;
					scan_issue_q <= scan_issue_q && !scan_done && (scan_addr_q != '1);
					if (scan_issue_q && (scan_addr_q != '1)) begin
						scan_addr_q <= scan_addr_q + shm_pkg::pix_t'(1);
					end
					if (rd_vld_s1) begin
						acc_q <= sum;
					end
					if (scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			upd_pix_q[0] <= shm_pkg::pix_t'(remove_top);
			upd_pix_q[1] <= shm_pkg::pix_t'(remove_mid);
			upd_pix_q[2] <= shm_pkg::pix_t'(remove_bottom);
			upd_pix_q[3] <= shm_pkg::pix_t'(add_top);
			upd_pix_q[4] <= shm_pkg::pix_t'(add_mid);
			upd_pix_q[5] <= shm_pkg::pix_t'(add_bottom);
			emit_q       <= emit;
		end
		if (state_q == ST_SCAN && scan_issue_q) begin
			rd_addr_s1 <= scan_addr_q;
		end
		if (state_q == ST_SCAN && scan_done) begin
			// last bin without a hit is the top value, which is rd_addr_s1 itself
			res_q <= rd_addr_s1;
		end
		if (state_q == ST_EMIT && out_free) begin
			median_q <= (shm_pkg::PORT_PIX_W)'(res_q);
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign median_value = median_q;

	// An accepted item blocks the input until its work is done
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again in the cycle after an accept");

	// A new result only comes out of the emit step
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

	// Histogram reset leaves bin zero valid
	a_clear_sets_bin0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> valid_q[0])
		else $error("bin zero not valid after histogram reset");

	// The update counter never runs past the last of six updates
	a_upd_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> (upd_cnt_q <= shm_pkg::UPD_LAST))
		else $error("bin update counter out of range");

endmodule

`default_nettype wire
